@@ src/gmt_pkg.sv @@
// package for the group membership table
// shared sizes, codes, entry layout and member address helper; no dependencies
`default_nettype none
package gmt_pkg;
   localparam int ENTRIES     = 256;
   localparam int MAX_MEMBERS = 16;
   localparam int IDX_W       = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
   localparam int CNT_W       = $clog2(ENTRIES + 1);
   localparam int MCNT_W      = 5;
   localparam int MADDR_W     = $clog2(ENTRIES * MAX_MEMBERS);
   localparam int ID_W        = 16;

   localparam logic signed [ID_W-1:0] OWN_LEAD_LIMIT = 16'sd10000;

   localparam logic [2:0] REQ_CREATE = 3'd0;
   localparam logic [2:0] REQ_LEAD   = 3'd1;
   localparam logic [2:0] REQ_ADD    = 3'd2;
   localparam logic [2:0] REQ_REMOVE = 3'd3;
   localparam logic [2:0] REQ_MEMBER = 3'd4;
   localparam logic [2:0] REQ_LEADER = 3'd5;

   localparam logic [3:0] STS_OK       = 4'd0;
   localparam logic [3:0] STS_NO_SUBJ  = 4'd1;
   localparam logic [3:0] STS_NO_OTHER = 4'd2;
   localparam logic [3:0] STS_EXISTS   = 4'd3;
   localparam logic [3:0] STS_TBL_FULL = 4'd4;
   localparam logic [3:0] STS_LST_FULL = 4'd5;
   localparam logic [3:0] STS_ALREADY  = 4'd6;
   localparam logic [3:0] STS_NOT_MEM  = 4'd7;
   localparam logic [3:0] STS_SAME_ID  = 4'd8;

   typedef struct packed {
      logic signed [ID_W-1:0] id;
      logic signed [ID_W-1:0] lead;
      logic [MCNT_W-1:0]      cnt;
      logic [IDX_W-1:0]       phys;
   } gmt_entry_type;

   localparam int ENT_W = $bits(gmt_entry_type);

   function automatic logic [MADDR_W-1:0] member_addr(input logic [IDX_W-1:0] phys,
                                                       input logic [MCNT_W-1:0] slot);
      member_addr = MADDR_W'(MADDR_W'(phys) * MADDR_W'(MAX_MEMBERS)) + MADDR_W'(slot);
   endfunction
endpackage
`default_nettype wire

@@ src/gmt_ram.sv @@
// generic simple dual port ram, one write and one registered read port
// no dependencies
`default_nettype none
module gmt_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  wire logic                     clock,
   input  wire logic                     we,
   input  wire logic [$clog2(DEPTH)-1:0] waddr,
   input  wire logic [WIDTH-1:0]         wdata,
   input  wire logic [$clog2(DEPTH)-1:0] raddr,
   output logic      [WIDTH-1:0]         rdata
);
   logic [WIDTH-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (we) begin
         mem[waddr] <= wdata;
      end
      rdata <= mem[raddr];
   end
endmodule
`default_nettype wire

@@ src/group_membership_table.sv @@
// top level of the group membership table: sequencer and the two table memories
// depends on gmt_pkg and gmt_ram
//
// One request is taken at a time and answered with one item. Entries sit sorted by id
// in an entry memory (id, leader, member count, home block of member slots); members
// live in a second memory in fixed blocks that never move. Every lookup is a binary
// search, a member scan reads one member after another, a create shifts the entries
// above its place up by one and a remove shifts the members behind the slot down by one.
// No clearing pass is needed.
`default_nettype none
module group_membership_table
   import gmt_pkg::*;
(
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_tvalid,
   output logic             req_tready,
   input  wire logic [31:0] req_tdata,  // subject_id, other_id
   input  wire logic [2:0]  req_tuser,  // req_type
   output logic             rsp_tvalid,
   input  wire logic        rsp_tready,
   output logic      [31:0] rsp_tdata   // status, answer, entry_lead, member_count, zero pad
);
   typedef enum logic [10:0] {
      ST_IDLE     = 11'b00000000001,
      ST_SRCH_RD  = 11'b00000000010,
      ST_SRCH_CMP = 11'b00000000100,
      ST_SCAN_RD  = 11'b00000001000,
      ST_SCAN_CMP = 11'b00000010000,
      ST_SHIFT_RD = 11'b00000100000,
      ST_SHIFT_WR = 11'b00001000000,
      ST_MREM_RD  = 11'b00010000000,
      ST_MREM_WR  = 11'b00100000000,
      ST_UPDATE   = 11'b01000000000,
      ST_RESP     = 11'b10000000000
   } state_type;

   state_type state_ff, state_in;
   logic [2:0] type_ff, type_in;
   logic signed [ID_W-1:0] subj_ff, subj_in, oth_ff, oth_in, target;
   logic [CNT_W-1:0] lo_ff, lo_in, hi_ff, hi_in, count_ff, count_in, shift_ff, shift_in;
   logic [CNT_W:0] sum;
   logic [CNT_W-1:0] mid;
   logic [IDX_W-1:0] mid_ff, mid_in, sidx_ff, sidx_in;
   logic other_ph_ff, other_ph_in, sfound_ff, sfound_in, madd_ff, madd_in;
   gmt_entry_type sent_ff, sent_in, rd_ent, new_ent;
   logic [MCNT_W-1:0] scan_ff, scan_in;
   logic [MADDR_W-1:0] maddr_ff, maddr_in;
   logic [3:0] status_ff, status_in;
   logic answer_ff, answer_in;
   logic rsp_valid_ff, rsp_valid_in;
   logic [31:0] rsp_data_ff, rsp_data_in;
   logic srch_end, scan_end, hit;

   logic e_we;
   logic [IDX_W-1:0] e_waddr, e_raddr;
   logic [ENT_W-1:0] e_wdata, e_rdata;
   logic m_we;
   logic [MADDR_W-1:0] m_waddr, m_raddr;
   logic [ID_W-1:0] m_wdata, m_rdata;

   gmt_ram #(.WIDTH(ENT_W), .DEPTH(ENTRIES)) u_entry_ram (
      .clock(clock), .we(e_we), .waddr(e_waddr), .wdata(e_wdata),
      .raddr(e_raddr), .rdata(e_rdata)
   );

   gmt_ram #(.WIDTH(ID_W), .DEPTH(ENTRIES * MAX_MEMBERS)) u_member_ram (
      .clock(clock), .we(m_we), .waddr(m_waddr), .wdata(m_wdata),
      .raddr(m_raddr), .rdata(m_rdata)
   );

   assign rd_ent     = gmt_entry_type'(e_rdata);
   assign target     = other_ph_ff ? oth_ff : subj_ff;
   assign sum        = {1'b0, lo_ff} + {1'b0, hi_ff};
   assign mid        = sum[CNT_W:1];
   assign req_tready = (state_ff == ST_IDLE);
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

   always_comb begin
      new_ent.id   = subj_ff;
      new_ent.lead = (subj_ff < OWN_LEAD_LIMIT) ? subj_ff : '0;
      new_ent.cnt  = '0;
      new_ent.phys = count_ff[IDX_W-1:0];
   end

   always_comb begin
      state_in     = state_ff;
      type_in      = type_ff;
      subj_in      = subj_ff;
      oth_in       = oth_ff;
      lo_in        = lo_ff;
      hi_in        = hi_ff;
      count_in     = count_ff;
      shift_in     = shift_ff;
      mid_in       = mid_ff;
      sidx_in      = sidx_ff;
      other_ph_in  = other_ph_ff;
      sfound_in    = sfound_ff;
      madd_in      = madd_ff;
      sent_in      = sent_ff;
      scan_in      = scan_ff;
      maddr_in     = maddr_ff;
      status_in    = status_ff;
      answer_in    = answer_ff;
      rsp_valid_in = rsp_valid_ff;
      rsp_data_in  = rsp_data_ff;
      srch_end     = 1'b0;
      scan_end     = 1'b0;
      hit          = 1'b0;
      e_we         = 1'b0;
      e_waddr      = sidx_ff;
      e_wdata      = sent_ff;
      e_raddr      = mid[IDX_W-1:0];
      m_we         = 1'b0;
      m_waddr      = maddr_ff;
      m_wdata      = oth_ff;
      m_raddr      = member_addr(sent_ff.phys, scan_ff);

      if (rsp_valid_ff && rsp_tready) begin
         rsp_valid_in = 1'b0;
      end

      case (state_ff)
         ST_IDLE: begin
            if (req_tvalid) begin
               type_in     = req_tuser;
               subj_in     = req_tdata[15:0];
               oth_in      = req_tdata[31:16];
               other_ph_in = 1'b0;
               sfound_in   = 1'b0;
               madd_in     = 1'b0;
               status_in   = STS_OK;
               answer_in   = 1'b0;
               lo_in       = '0;
               hi_in       = count_ff;
               state_in    = ST_SRCH_RD;
            end
         end
         ST_SRCH_RD: begin
            if (lo_ff < hi_ff) begin
               mid_in   = mid[IDX_W-1:0];
               state_in = ST_SRCH_CMP;
            end else begin
               srch_end = 1'b1;
            end
         end
         ST_SRCH_CMP: begin
            if (rd_ent.id == target) begin
               srch_end = 1'b1;
               hit      = 1'b1;
            end else if (rd_ent.id < target) begin
               lo_in    = CNT_W'(mid_ff) + CNT_W'(1);
               state_in = ST_SRCH_RD;
            end else begin
               hi_in    = CNT_W'(mid_ff);
               state_in = ST_SRCH_RD;
            end
         end
         ST_SCAN_RD: begin
            if (scan_ff < sent_ff.cnt) begin
               state_in = ST_SCAN_CMP;
            end else begin
               scan_end = 1'b1;
            end
         end
         ST_SCAN_CMP: begin
            if ($signed(m_rdata) == oth_ff) begin
               scan_end = 1'b1;
               hit      = 1'b1;
            end else begin
               scan_in  = scan_ff + MCNT_W'(1);
               state_in = ST_SCAN_RD;
            end
         end
         ST_SHIFT_RD: begin
            e_raddr = IDX_W'(shift_ff - CNT_W'(1));
            if (shift_ff > CNT_W'(sidx_ff)) begin
               state_in = ST_SHIFT_WR;
            end else begin
               sent_in   = new_ent;
               sfound_in = 1'b1;
               count_in  = count_ff + CNT_W'(1);
               state_in  = ST_UPDATE;
            end
         end
         ST_SHIFT_WR: begin
            e_we     = 1'b1;
            e_waddr  = shift_ff[IDX_W-1:0];
            e_wdata  = e_rdata;
            shift_in = shift_ff - CNT_W'(1);
            state_in = ST_SHIFT_RD;
         end
         ST_MREM_RD: begin
            if (scan_ff < sent_ff.cnt) begin
               state_in = ST_MREM_WR;
            end else begin
               sent_in.cnt = sent_ff.cnt - MCNT_W'(1);
               state_in    = ST_UPDATE;
            end
         end
         ST_MREM_WR: begin
            m_we     = 1'b1;
            m_waddr  = member_addr(sent_ff.phys, scan_ff - MCNT_W'(1));
            m_wdata  = m_rdata;
            scan_in  = scan_ff + MCNT_W'(1);
            state_in = ST_MREM_RD;
         end
         ST_UPDATE: begin
            e_we     = 1'b1;
            m_we     = madd_ff;
            state_in = ST_RESP;
         end
         ST_RESP: begin
            if (!rsp_valid_ff || rsp_tready) begin
               rsp_valid_in = 1'b1;
               rsp_data_in  = {6'd0,
                               sfound_ff ? sent_ff.cnt : MCNT_W'(0),
                               sfound_ff ? sent_ff.lead : 16'sd0,
                               answer_ff, status_ff};
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase

      if (srch_end && !other_ph_ff) begin
         sfound_in = hit;
         sent_in   = rd_ent;
         sidx_in   = hit ? mid_ff : lo_ff[IDX_W-1:0];
         state_in  = ST_RESP;
         case (type_ff)
            REQ_CREATE: begin
               if (hit) begin
                  status_in = STS_EXISTS;
               end else if (count_ff == CNT_W'(ENTRIES)) begin
                  status_in = STS_TBL_FULL;
               end else begin
                  shift_in = count_ff;
                  state_in = ST_SHIFT_RD;
               end
            end
            REQ_LEAD: begin
               if (!hit) begin
                  status_in = STS_NO_SUBJ;
               end else if (oth_ff == 16'sd0) begin
                  sent_in.lead = '0;
                  state_in     = ST_UPDATE;
               end else begin
                  other_ph_in = 1'b1;
                  lo_in       = '0;
                  hi_in       = count_ff;
                  state_in    = ST_SRCH_RD;
               end
            end
            REQ_ADD, REQ_REMOVE: begin
               if (!hit) begin
                  status_in = STS_NO_SUBJ;
               end else begin
                  other_ph_in = 1'b1;
                  lo_in       = '0;
                  hi_in       = count_ff;
                  state_in    = ST_SRCH_RD;
               end
            end
            REQ_MEMBER: begin
               if (!hit) begin
                  status_in = STS_NO_SUBJ;
                  answer_in = (oth_ff == subj_ff);
               end else if (oth_ff == subj_ff) begin
                  answer_in = 1'b1;
               end else begin
                  scan_in  = '0;
                  state_in = ST_SCAN_RD;
               end
            end
            REQ_LEADER: begin
               if (!hit) begin
                  status_in = STS_NO_SUBJ;
               end else if (oth_ff == 16'sd0) begin
                  answer_in = 1'b0;
               end else if (rd_ent.lead == oth_ff) begin
                  answer_in = 1'b1;
               end else if (rd_ent.lead != 16'sd0) begin
                  answer_in = 1'b0;
               end else if (oth_ff == subj_ff) begin
                  answer_in = 1'b1;
               end else begin
                  scan_in  = '0;
                  state_in = ST_SCAN_RD;
               end
            end
            default: begin
            end
         endcase
      end

      if (srch_end && other_ph_ff) begin
         state_in = ST_RESP;
         if (!hit) begin
            status_in = STS_NO_OTHER;
         end else begin
            case (type_ff)
               REQ_LEAD: begin
                  sent_in.lead = oth_ff;
                  state_in     = ST_UPDATE;
               end
               REQ_ADD: begin
                  if (oth_ff == subj_ff) begin
                     status_in = STS_SAME_ID;
                  end else if (sent_ff.cnt >= MCNT_W'(MAX_MEMBERS)) begin
                     status_in = STS_LST_FULL;
                  end else begin
                     scan_in  = '0;
                     state_in = ST_SCAN_RD;
                  end
               end
               REQ_REMOVE: begin
                  scan_in  = '0;
                  state_in = ST_SCAN_RD;
               end
               default: begin
               end
            endcase
         end
      end

      if (scan_end) begin
         state_in = ST_RESP;
         case (type_ff)
            REQ_ADD: begin
               if (hit) begin
                  status_in = STS_ALREADY;
               end else begin
                  madd_in     = 1'b1;
                  maddr_in    = member_addr(sent_ff.phys, sent_ff.cnt);
                  sent_in.cnt = sent_ff.cnt + MCNT_W'(1);
                  state_in    = ST_UPDATE;
               end
            end
            REQ_REMOVE: begin
               if (!hit) begin
                  status_in = STS_NOT_MEM;
               end else begin
                  scan_in  = scan_ff + MCNT_W'(1);
                  state_in = ST_MREM_RD;
               end
            end
            default: begin
               answer_in = hit;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      type_ff     <= type_in;
      subj_ff     <= subj_in;
      oth_ff      <= oth_in;
      lo_ff       <= lo_in;
      hi_ff       <= hi_in;
      shift_ff    <= shift_in;
      mid_ff      <= mid_in;
      sidx_ff     <= sidx_in;
      other_ph_ff <= other_ph_in;
      sfound_ff   <= sfound_in;
      madd_ff     <= madd_in;
      sent_ff     <= sent_in;
      scan_ff     <= scan_in;
      maddr_ff    <= maddr_in;
      status_ff   <= status_in;
      answer_ff   <= answer_in;
      rsp_data_ff <= rsp_data_in;
   end
endmodule
`default_nettype wire
